// ===== rtl/rsa_pkg.sv =====
// shared types and constants for the running statistics aggregator
`default_nettype none
package rsa_pkg;

    localparam int SAMPLE_W = 32;
    localparam int AGG_W    = 48;
    localparam int CNT_W    = 16;
    localparam int ACC_W    = 64;
    localparam int PROD_W   = 2 * ACC_W;
    localparam int DVS_W    = 32;
    localparam int ROOT_W   = 64;
    localparam int MODE_W   = 3;
    localparam int STAT_W   = 2;

    localparam int MAX_GROUP_DEF = 65535;
    localparam int FRAC_BITS_DEF = 16;

    localparam logic [MODE_W-1:0] MODE_SUM      = 3'd0;
    localparam logic [MODE_W-1:0] MODE_MIN      = 3'd1;
    localparam logic [MODE_W-1:0] MODE_MAX      = 3'd2;
    localparam logic [MODE_W-1:0] MODE_MEAN     = 3'd3;
    localparam logic [MODE_W-1:0] MODE_STDDEV   = 3'd4;
    localparam logic [MODE_W-1:0] MODE_RCP_SUM  = 3'd5;
    localparam logic [MODE_W-1:0] MODE_RCP_MEAN = 3'd6;
    localparam logic [MODE_W-1:0] MODE_UNDEF    = 3'd7;

    localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
    localparam logic [STAT_W-1:0] STAT_RCP0   = 2'd1;
    localparam logic [STAT_W-1:0] STAT_ONE    = 2'd2;
    localparam logic [STAT_W-1:0] STAT_SAT    = 2'd3;

    typedef struct packed {
        logic              go;
        logic [ACC_W-1:0]  mcand;
        logic [ACC_W-1:0]  mplier;
        logic [6:0]        steps;
    } t_mul_req;

    typedef struct packed {
        logic              go;
        logic [PROD_W-1:0] dividend;
        logic [DVS_W-1:0]  divisor;
        logic [7:0]        steps;
    } t_div_req;

    typedef struct packed {
        logic              go;
        logic [PROD_W-1:0] radicand;
    } t_sqrt_req;

endpackage
`default_nettype wire

// ===== rtl/rsa_mul.sv =====
// bit-serial shift-and-add multiplier, multiplier bits msb first
`default_nettype none
module rsa_mul (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire rsa_pkg::t_mul_req         i_req,
    output logic                           o_done,
    output logic [rsa_pkg::PROD_W-1:0]     o_product
);
    import rsa_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [6:0]        r_cnt;
    logic [ACC_W-1:0]  r_a;
    logic [ACC_W-1:0]  r_b;
    logic [PROD_W-1:0] r_p;
    logic [PROD_W-1:0] n_p;

    always_comb begin
        n_p = {r_p[PROD_W-2:0], 1'b0};
        if (r_b[ACC_W-1]) begin
            n_p = n_p + {{ACC_W{1'b0}}, r_a};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.go) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
                r_a    <= i_req.mcand;
                r_b    <= i_req.mplier;
                r_p    <= '0;
            end else if (r_busy) begin
                r_p   <= n_p;
                r_b   <= {r_b[ACC_W-2:0], 1'b0};
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done    = r_done;
    assign o_product = r_p;
endmodule
`default_nettype wire

// ===== rtl/rsa_div.sv =====
// bit-serial restoring divider, dividend bits msb first
`default_nettype none
module rsa_div (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire rsa_pkg::t_div_req         i_req,
    output logic                           o_done,
    output logic [rsa_pkg::PROD_W-1:0]     o_quotient
);
    import rsa_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [7:0]        r_cnt;
    logic [PROD_W-1:0] r_dvd;
    logic [DVS_W-1:0]  r_dvs;
    logic [DVS_W-1:0]  r_rem;
    logic [PROD_W-1:0] r_quo;
    logic [DVS_W:0]    w_rem_sh;
    logic [DVS_W:0]    w_diff;
    logic              w_ge;

    assign w_rem_sh = {r_rem, r_dvd[PROD_W-1]};
    assign w_ge     = (w_rem_sh >= {1'b0, r_dvs});
    assign w_diff   = w_rem_sh - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.go) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
                r_dvd  <= i_req.dividend;
                r_dvs  <= i_req.divisor;
                r_rem  <= '0;
                r_quo  <= '0;
            end else if (r_busy) begin
                r_rem <= w_ge ? w_diff[DVS_W-1:0] : w_rem_sh[DVS_W-1:0];
                r_quo <= {r_quo[PROD_W-2:0], w_ge};
                r_dvd <= {r_dvd[PROD_W-2:0], 1'b0};
                r_cnt <= r_cnt - 8'd1;
                if (r_cnt == 8'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;
endmodule
`default_nettype wire

// ===== rtl/rsa_sqrt.sv =====
// digit-serial integer square root, two radicand bits per cycle
`default_nettype none
module rsa_sqrt (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire rsa_pkg::t_sqrt_req        i_req,
    output logic                           o_done,
    output logic [rsa_pkg::ROOT_W-1:0]     o_root
);
    import rsa_pkg::*;

    localparam int REM_W = ROOT_W + 2;

    logic              r_busy;
    logic              r_done;
    logic [6:0]        r_cnt;
    logic [PROD_W-1:0] r_rad;
    logic [REM_W-1:0]  r_rem;
    logic [ROOT_W-1:0] r_root;
    logic [REM_W+1:0]  w_rem_sh;
    logic [REM_W+1:0]  w_trial;
    logic [REM_W+1:0]  w_diff;
    logic              w_ge;

    assign w_rem_sh = {r_rem, r_rad[PROD_W-1:PROD_W-2]};
    assign w_trial  = {2'b00, r_root, 2'b01};
    assign w_ge     = (w_rem_sh >= w_trial);
    assign w_diff   = w_rem_sh - w_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.go) begin
                r_busy <= 1'b1;
                r_cnt  <= 7'(ROOT_W);
                r_rad  <= i_req.radicand;
                r_rem  <= '0;
                r_root <= '0;
            end else if (r_busy) begin
                r_rem  <= w_ge ? w_diff[REM_W-1:0] : w_rem_sh[REM_W-1:0];
                r_root <= {r_root[ROOT_W-2:0], w_ge};
                r_rad  <= {r_rad[PROD_W-3:0], 2'b00};
                r_cnt  <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;
endmodule
`default_nettype wire

// ===== rtl/running_statistics_aggregator.sv =====
// top level: sample intake, accumulators, group close sequencer and result register
//
// channel   dir  handshake                   payload
// s_axis    in   s_axis_tvalid/tready        tdata[31:0] sample, tlast group_end
// m_axis    out  m_axis_tvalid/tready        tdata agg[47:0], count[63:48], status[65:64]
// config    in   i_cfg_wr_en                 i_cfg_wr_data mode
//
// one sample at a time: sum, mean, min, max go straight to accumulation, stddev first
// squares the sample (serial multiplier), reciprocal modes first take the reciprocal (serial divider)
// closing a group for stddev runs the multiplier, two divides and the root in turn
// s_axis_tready is low while a sample or a group close is in progress
// a finished result waits in the output register; the next close waits for it to go
// synchronous active-low reset clears mode and all accumulators
`default_nettype none
module running_statistics_aggregator #(
    parameter int MAX_GROUP = rsa_pkg::MAX_GROUP_DEF,
    parameter int FRAC_BITS = rsa_pkg::FRAC_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [2:0]  i_cfg_wr_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [31:0] sample
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [71:0]      m_axis_tdata    // [47:0] aggregate, [63:48] item_count, [65:64] status
);
    import rsa_pkg::*;

    localparam logic signed [ACC_W-1:0] S64_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] S64_MIN = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic [AGG_W-1:0] AGG_MAX = {1'b0, {(AGG_W-1){1'b1}}};
    localparam logic [AGG_W-1:0] AGG_MIN = {1'b1, {(AGG_W-1){1'b0}}};

    typedef enum logic [3:0] {
        S_IDLE, S_SQ_W, S_RCP_W, S_ACC, S_FIN, S_MEAN_W,
        S_SD_MUL_W, S_SD_D1_W, S_SD_D2_W, S_SD_SQ_W, S_CLAMP, S_OUT
    } t_state;

    t_state                  r_state;
    logic [MODE_W-1:0]       r_mode;
    logic [MODE_W-1:0]       r_m;
    logic signed [SAMPLE_W-1:0] r_s;
    logic                    r_close;
    logic signed [ACC_W-1:0] r_sum;
    logic [ACC_W-1:0]        r_sqs;
    logic [ACC_W-1:0]        r_sq;
    logic signed [ACC_W-1:0] r_term;
    logic signed [SAMPLE_W-1:0] r_ext;
    logic [CNT_W-1:0]        r_cnt;
    logic [1:0]              r_err;
    logic signed [ACC_W-1:0] r_val;
    logic                    r_neg;
    logic [AGG_W-1:0]        r_agg;
    logic [STAT_W-1:0]       r_stat;
    logic [AGG_W-1:0]        r_oagg;
    logic [CNT_W-1:0]        r_ocnt;
    logic [STAT_W-1:0]       r_ostat;
    logic                    r_ovalid;
    t_mul_req                r_mul;
    t_div_req                r_div;
    t_sqrt_req               r_sqrt;

    logic                    w_mul_done;
    logic [PROD_W-1:0]       w_prod;
    logic                    w_div_done;
    logic [PROD_W-1:0]       w_quo;
    logic                    w_sqrt_done;
    logic [ROOT_W-1:0]       w_root;

    logic                    w_acc;
    logic signed [SAMPLE_W-1:0] w_s_in;
    logic [CNT_W-1:0]        w_cnt_inc;
    logic [SAMPLE_W-1:0]     w_s_mag;
    logic [ACC_W-1:0]        w_sum_mag;
    logic signed [ACC_W-1:0] w_add;
    logic                    w_ovf;
    logic signed [ACC_W-1:0] w_sum_sat;
    logic [ACC_W-1:0]        w_sqs_add;
    logic                    w_sqs_ovf;
    logic [ACC_W-1:0]        w_diff;
    logic                    w_fits;

    rsa_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (r_mul),
        .o_done    (w_mul_done),
        .o_product (w_prod)
    );

    rsa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (r_div),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    rsa_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_sqrt),
        .o_done  (w_sqrt_done),
        .o_root  (w_root)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_acc         = s_axis_tvalid && s_axis_tready;
    assign w_s_in        = s_axis_tdata;
    assign w_cnt_inc     = r_cnt + CNT_W'(1);
    assign w_s_mag       = r_s[SAMPLE_W-1] ? SAMPLE_W'(-r_s) : r_s;
    assign w_sum_mag     = r_sum[ACC_W-1] ? ACC_W'(-r_sum) : r_sum;

    assign w_add     = r_sum + r_term;
    assign w_ovf     = (r_sum[ACC_W-1] == r_term[ACC_W-1]) && (w_add[ACC_W-1] != r_sum[ACC_W-1]);
    assign w_sum_sat = w_ovf ? (r_term[ACC_W-1] ? S64_MIN : S64_MAX) : w_add;
    assign w_sqs_add = r_sqs + r_sq;
    assign w_sqs_ovf = w_sqs_add[ACC_W-1];

    assign w_diff = ((w_quo[PROD_W-1:ACC_W] != '0) || (w_quo[ACC_W-1:0] > r_sqs)) ?
                    '0 : (r_sqs - w_quo[ACC_W-1:0]);
    assign w_fits = (r_val[ACC_W-1:AGG_W-1] == '0) || (r_val[ACC_W-1:AGG_W-1] == '1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_mode   <= MODE_SUM;
            r_sum    <= '0;
            r_sqs    <= '0;
            r_ext    <= '0;
            r_cnt    <= '0;
            r_err    <= '0;
            r_ovalid <= 1'b0;
            r_mul    <= '0;
            r_div    <= '0;
            r_sqrt   <= '0;
        end else begin
            r_mul.go  <= 1'b0;
            r_div.go  <= 1'b0;
            r_sqrt.go <= 1'b0;
            if (i_cfg_wr_en) begin
                r_mode <= i_cfg_wr_data;
            end
            if (r_ovalid && m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_acc) begin
                        r_s     <= w_s_in;
                        r_m     <= (r_mode == MODE_UNDEF) ? MODE_SUM : r_mode;
                        r_cnt   <= w_cnt_inc;
                        r_close <= s_axis_tlast || (w_cnt_inc >= CNT_W'(MAX_GROUP));
                        r_term  <= ACC_W'(w_s_in);
                        r_state <= S_ACC;
                        if (r_mode == MODE_STDDEV) begin
                            r_state <= S_SQ_W;
                        end else if (r_mode == MODE_RCP_SUM || r_mode == MODE_RCP_MEAN) begin
                            r_state <= S_RCP_W;
                        end
                    end
                end
                S_SQ_W: begin
                    if (!r_mul.go && !w_mul_done && r_mul.steps == '0) begin
                        r_mul.go     <= 1'b1;
                        r_mul.mcand  <= ACC_W'(w_s_mag);
                        r_mul.mplier <= {w_s_mag, {(ACC_W-SAMPLE_W){1'b0}}};
                        r_mul.steps  <= 7'(SAMPLE_W);
                    end else if (w_mul_done) begin
                        r_mul.steps <= '0;
                        r_sq        <= w_prod[ACC_W-1:0] >> FRAC_BITS;
                        r_state     <= S_ACC;
                    end
                end
                S_RCP_W: begin
                    if (r_s == '0) begin
                        r_err[0] <= 1'b1;
                        r_state  <= r_close ? S_FIN : S_IDLE;
                    end else if (!r_div.go && !w_div_done && r_div.steps == '0) begin
                        r_div.go       <= 1'b1;
                        r_div.dividend <= {1'b1, {(PROD_W-1){1'b0}}};
                        r_div.divisor  <= w_s_mag;
                        r_div.steps    <= 8'(2 * FRAC_BITS + 1);
                    end else if (w_div_done) begin
                        r_div.steps <= '0;
                        r_term  <= r_s[SAMPLE_W-1] ? -$signed(w_quo[ACC_W-1:0])
                                                   : $signed(w_quo[ACC_W-1:0]);
                        r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    case (r_m)
                        MODE_MIN: begin
                            if (r_cnt == CNT_W'(1) || r_s < r_ext) begin
                                r_ext <= r_s;
                            end
                        end
                        MODE_MAX: begin
                            if (r_cnt == CNT_W'(1) || r_s > r_ext) begin
                                r_ext <= r_s;
                            end
                        end
                        default: begin
                            r_sum <= w_sum_sat;
                            if (w_ovf) begin
                                r_err[1] <= 1'b1;
                            end
                            if (r_m == MODE_STDDEV) begin
                                if (w_sqs_ovf) begin
                                    r_sqs    <= S64_MAX;
                                    r_err[1] <= 1'b1;
                                end else begin
                                    r_sqs <= w_sqs_add;
                                end
                            end
                        end
                    endcase
                    r_state <= r_close ? S_FIN : S_IDLE;
                end
                S_FIN: begin
                    r_neg <= r_sum[ACC_W-1];
                    if (r_err[0]) begin
                        r_agg   <= AGG_MAX;
                        r_stat  <= STAT_RCP0;
                        r_state <= S_OUT;
                    end else if (r_m == MODE_STDDEV && r_cnt == CNT_W'(1)) begin
                        r_agg   <= '0;
                        r_stat  <= STAT_ONE;
                        r_state <= S_OUT;
                    end else begin
                        case (r_m)
                            MODE_MIN, MODE_MAX: begin
                                r_val   <= ACC_W'(r_ext);
                                r_state <= S_CLAMP;
                            end
                            MODE_MEAN, MODE_RCP_MEAN: begin
                                r_div.go       <= 1'b1;
                                r_div.dividend <= {w_sum_mag, {ACC_W{1'b0}}};
                                r_div.divisor  <= DVS_W'(r_cnt);
                                r_div.steps    <= 8'(ACC_W);
                                r_state        <= S_MEAN_W;
                            end
                            MODE_STDDEV: begin
                                r_mul.go     <= 1'b1;
                                r_mul.mcand  <= w_sum_mag;
                                r_mul.mplier <= w_sum_mag;
                                r_mul.steps  <= 7'(ACC_W);
                                r_state      <= S_SD_MUL_W;
                            end
                            default: begin
                                r_val   <= r_sum;
                                r_state <= S_CLAMP;
                            end
                        endcase
                    end
                end
                S_MEAN_W: begin
                    if (w_div_done) begin
                        r_div.steps <= '0;
                        r_val   <= r_neg ? -$signed(w_quo[ACC_W-1:0])
                                         : $signed(w_quo[ACC_W-1:0]);
                        r_state <= S_CLAMP;
                    end
                end
                S_SD_MUL_W: begin
                    if (w_mul_done) begin
                        r_mul.steps    <= '0;
                        r_div.go       <= 1'b1;
                        r_div.dividend <= w_prod >> FRAC_BITS;
                        r_div.divisor  <= DVS_W'(r_cnt);
                        r_div.steps    <= 8'(PROD_W);
                        r_state        <= S_SD_D1_W;
                    end
                end
                S_SD_D1_W: begin
                    if (w_div_done) begin
                        r_div.go       <= 1'b1;
                        r_div.dividend <= {w_diff, {ACC_W{1'b0}}};
                        r_div.divisor  <= DVS_W'(r_cnt - CNT_W'(1));
                        r_div.steps    <= 8'(ACC_W);
                        r_state        <= S_SD_D2_W;
                    end
                end
                S_SD_D2_W: begin
                    if (w_div_done) begin
                        r_div.steps     <= '0;
                        r_sqrt.go       <= 1'b1;
                        r_sqrt.radicand <= {{ACC_W{1'b0}}, w_quo[ACC_W-1:0]} << FRAC_BITS;
                        r_state         <= S_SD_SQ_W;
                    end
                end
                S_SD_SQ_W: begin
                    if (w_sqrt_done) begin
                        r_val   <= $signed(w_root);
                        r_state <= S_CLAMP;
                    end
                end
                S_CLAMP: begin
                    if (w_fits) begin
                        r_agg  <= r_val[AGG_W-1:0];
                        r_stat <= r_err[1] ? STAT_SAT : STAT_OK;
                    end else begin
                        r_agg  <= r_val[ACC_W-1] ? AGG_MIN : AGG_MAX;
                        r_stat <= STAT_SAT;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_ovalid || m_axis_tready) begin
                        r_oagg   <= r_agg;
                        r_ocnt   <= r_cnt;
                        r_ostat  <= r_stat;
                        r_ovalid <= 1'b1;
                        r_sum    <= '0;
                        r_sqs    <= '0;
                        r_ext    <= '0;
                        r_cnt    <= '0;
                        r_err    <= '0;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {6'd0, r_ostat, r_ocnt, r_oagg};
endmodule
`default_nettype wire
